/* sv/cf24_pkg.sv */
// shared types, codes and scale table for the compact float24 decoder
package cf24_pkg;

  localparam int unsigned MANT_W  = 24;
  localparam int unsigned REM_W   = MANT_W + 1;
  localparam int unsigned QUO_W   = 26;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = QUO_W / BITS_PER_STAGE;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [7:0] CODE_ZERO       = 8'h00;
  localparam logic [7:0] CODE_ONE        = 8'hFF;
  localparam logic [7:0] CODE_BYTE_FIRST = 8'h01;
  localparam logic [7:0] CODE_WIDE_FIRST = 8'h06;
  localparam logic [7:0] CODE_WIDE_END   = 8'h0E;

  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

  // exponent of the quotient before the integer bit is known: 127 + 15 + 127
  localparam logic [9:0] EXP_BIAS_SUM = 10'd269;

  typedef enum logic [1:0] {
    USED_NONE = 2'd0,
    USED_BYTE = 2'd1,
    USED_WIDE = 2'd2,
    USED_MANT = 2'd3
  } used_t;

  typedef struct packed {
    logic        direct;
    logic        sign;
    logic        zero;
    used_t       used;
    logic [31:0] bits;
    logic [7:0]  exp_base;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  r;
    logic [MANT_W-1:0] d;
    logic [QUO_W-1:0]  q;
    side_t             side;
  } div_t;

  typedef struct packed {
    logic [7:0]        exp;
    logic [MANT_W-1:0] mant;
  } scale_t;

  // scales as float32 repeated multiplication by ten produces them
  function automatic scale_t scale_lookup(input logic [3:0] idx);
    scale_t s;
    case (idx)
      4'd0:    s = '{exp: 8'h7B, mant: 24'hCCCCCD};
      4'd1:    s = '{exp: 8'h7F, mant: 24'h800000};
      4'd2:    s = '{exp: 8'h82, mant: 24'hA00000};
      4'd3:    s = '{exp: 8'h85, mant: 24'hC80000};
      4'd4:    s = '{exp: 8'h88, mant: 24'hFA0000};
      4'd5:    s = '{exp: 8'h75, mant: 24'h83126F};
      4'd6:    s = '{exp: 8'h78, mant: 24'hA3D70B};
      4'd7:    s = '{exp: 8'h7B, mant: 24'hCCCCCE};
      4'd8:    s = '{exp: 8'h7F, mant: 24'h800001};
      4'd9:    s = '{exp: 8'h82, mant: 24'hA00001};
      4'd10:   s = '{exp: 8'h85, mant: 24'hC80001};
      4'd11:   s = '{exp: 8'h88, mant: 24'hFA0001};
      4'd12:   s = '{exp: 8'h8C, mant: 24'h9C4001};
      default: s = '{exp: 8'h7F, mant: 24'h800000};
    endcase
    return s;
  endfunction

endpackage

/* sv/cf24_div_stage.sv */
// one pipelined restoring division stage, two quotient bits per stage
module cf24_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  cf24_pkg::div_t st_i,
  output logic           vld_o,
  output cf24_pkg::div_t st_o
);

  logic           vld_r;
  cf24_pkg::div_t st_r;
  cf24_pkg::div_t st_nxt;

  always_comb begin
    st_nxt = st_i;
    for (int i = 0; i < cf24_pkg::BITS_PER_STAGE; i++) begin
      if (st_nxt.r >= {1'b0, st_nxt.d}) begin
        st_nxt.q = {st_nxt.q[cf24_pkg::QUO_W-2:0], 1'b1};
        st_nxt.r = st_nxt.r - {1'b0, st_nxt.d};
      end else begin
        st_nxt.q = {st_nxt.q[cf24_pkg::QUO_W-2:0], 1'b0};
      end
      st_nxt.r = {st_nxt.r[cf24_pkg::REM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;

endmodule

/* sv/compact_float24_decoder_top.sv */
// compact float24 decoder: code byte and payloads to ieee single-precision bits
// pipeline: decode register, 13 divider stages, then rounding into the output register
// throughput: one beat per cycle unless the output stalls; the divider retires two quotient bits per stage
// the whole pipeline advances when the output register is empty or being taken
// reset: synchronous active-low rst_n clears all valid bits; data registers keep no reset
module compact_float24_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // code[7:0], small_value[15:8], mid_value[31:16], mant_low[39:32], mant_high[47:40]
  input  logic [cf24_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // value_bits[31:0], payload_used[33:32], zero[39:34]
  output logic [cf24_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned NS = cf24_pkg::DIV_STAGES;

  logic en;

  logic [7:0]        code;
  logic signed [7:0] small_value;
  logic signed [15:0] mid_value;
  logic [7:0]        mant_low;
  logic [7:0]        mant_high;

  assign code        = in_tdata[7:0];
  assign small_value = in_tdata[15:8];
  assign mid_value   = in_tdata[31:16];
  assign mant_low    = in_tdata[39:32];
  assign mant_high   = in_tdata[47:40];

  // decode and normalize
  cf24_pkg::div_t   dec;
  cf24_pkg::scale_t scl;
  logic [15:0]      mag;
  logic [15:0]      mag_n;
  logic [3:0]       lz;
  logic [3:0]       sidx;
  logic [15:0]      sv_ext;
  logic [15:0]      wv;

  always_comb begin
    sidx   = 4'(code - cf24_pkg::CODE_BYTE_FIRST);
    scl    = cf24_pkg::scale_lookup(sidx);
    sv_ext = {{8{small_value[7]}}, small_value};
    wv     = 16'(mid_value);
    dec    = '0;
    mag    = '0;
    if (code == cf24_pkg::CODE_ZERO) begin
      dec.side.direct = 1'b1;
      dec.side.bits   = '0;
      dec.side.used   = cf24_pkg::USED_NONE;
    end else if (code == cf24_pkg::CODE_ONE) begin
      dec.side.direct = 1'b1;
      dec.side.bits   = cf24_pkg::ONE_BITS;
      dec.side.used   = cf24_pkg::USED_NONE;
    end else if (code < cf24_pkg::CODE_WIDE_FIRST) begin
      dec.side.sign = sv_ext[15];
      mag           = sv_ext[15] ? 16'(-sv_ext) : sv_ext;
      dec.side.used = cf24_pkg::USED_BYTE;
    end else if (code < cf24_pkg::CODE_WIDE_END) begin
      dec.side.sign = wv[15];
      mag           = wv[15] ? 16'(-wv) : wv;
      dec.side.used = cf24_pkg::USED_WIDE;
    end else begin
      dec.side.direct = 1'b1;
      dec.side.bits   = {mant_low[0], code, mant_high, mant_low[7:1], 8'h00};
      dec.side.used   = cf24_pkg::USED_MANT;
    end
    lz = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) begin
        lz = 4'(15 - i);
      end
    end
    mag_n         = mag << lz;
    dec.side.zero = (mag == 16'd0);
    dec.d         = scl.mant;
    dec.r         = {1'b0, mag_n, 8'h00};
    dec.side.exp_base = 8'(cf24_pkg::EXP_BIAS_SUM - 10'(lz) - 10'(scl.exp));
  end

  logic           vld [0:NS];
  cf24_pkg::div_t stg [0:NS];
  logic           vld0_r;
  cf24_pkg::div_t stg0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg0_r <= dec;
    end
  end

  assign vld[0] = vld0_r;
  assign stg[0] = stg0_r;

  for (genvar g = 0; g < NS; g++) begin : g_div
    cf24_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld[g]),
      .st_i  (stg[g]),
      .vld_o (vld[g+1]),
      .st_o  (stg[g+1])
    );
  end

  // round to nearest even
  cf24_pkg::div_t   fin;
  logic [23:0]      m24;
  logic             grd;
  logic             stk;
  logic             rup;
  logic [7:0]       fexp;
  logic [30:0]      mag_bits;
  logic [31:0]      res_bits;

  always_comb begin
    fin = stg[NS];
    if (fin.q[25]) begin
      m24  = fin.q[25:2];
      grd  = fin.q[1];
      stk  = fin.q[0] | (fin.r != '0);
      fexp = fin.side.exp_base;
    end else begin
      m24  = fin.q[24:1];
      grd  = fin.q[0];
      stk  = (fin.r != '0);
      fexp = fin.side.exp_base - 8'd1;
    end
    rup      = grd & (stk | m24[0]);
    mag_bits = {fexp, m24[22:0]} + {30'd0, rup};
    if (fin.side.direct) begin
      res_bits = fin.side.bits;
    end else if (fin.side.zero) begin
      res_bits = '0;
    end else begin
      res_bits = {fin.side.sign, mag_bits};
    end
  end

  logic        out_vld_r;
  logic [31:0] out_bits_r;
  logic [1:0]  out_used_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bits_r <= res_bits;
      out_used_r <= fin.side.used;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_used_r, out_bits_r};

`ifndef ASSERT_OFF
  a_none_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_used_r == cf24_pkg::USED_NONE |->
      out_bits_r == '0 || out_bits_r == cf24_pkg::ONE_BITS)
    else $error("constant code gave another pattern");

  a_mant_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_used_r == cf24_pkg::USED_MANT |-> out_bits_r[7:0] == 8'h00)
    else $error("exponent form with nonzero low mantissa byte");

  a_quot_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_used_r == cf24_pkg::USED_BYTE || out_used_r == cf24_pkg::USED_WIDE)
      && out_bits_r != '0 |-> out_bits_r[30:23] != 8'h00 && out_bits_r[30:23] != 8'hFF)
    else $error("scaled quotient left the normal range");
`endif

endmodule
